// ----- design/lwgd_pkg.sv -----
// ----------------------------------------------------------------------------
// lwgd_pkg
// Types, widths and codes shared by the linear weight grid deposit and gather
// block: request and response beats, the queue entry and the status codes.
// ----------------------------------------------------------------------------
package lwgd_pkg;

   localparam int POS_W             = 26;
   localparam int VAL_W             = 32;
   localparam int FIELD_W           = 48;
   localparam int STATUS_W          = 2;
   localparam int GRID_POINTS_W     = 11;
   localparam int GRID_DEPTH_DEFAULT = 1024;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [GRID_POINTS_W-1:0] GRID_POINTS_RESET = 11'd1024;

   localparam logic KIND_DEPOSIT = 1'b0;
   localparam logic KIND_GATHER  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OFF_GRID  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

   typedef struct packed {
      logic                     kind;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  deposit_value;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] field_value;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic                     kind;
      logic                     off_grid;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  deposit_value;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

// ----- design/lwgd_ram.sv -----
// ----------------------------------------------------------------------------
// lwgd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lwgd_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lwgd_front.sv -----
// ----------------------------------------------------------------------------
// lwgd_front
// Accepts request beats, checks the position against the grid size in use
// and queues the classified item for the back end.
// ----------------------------------------------------------------------------
module lwgd_front
   import lwgd_pkg::*;
#(
   parameter int GRID_DEPTH = GRID_DEPTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_payload,
   input  logic [GRID_POINTS_W-1:0] grid_points,
   input  back_status_type          back_status,
   output queue_head_type           queue_head
);

   queue_item_type queue_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   logic           push;
   logic           pop;
   logic [31:0]    points_in_use;
   logic [31:0]    idx_next;
   queue_item_type item;

   always_comb begin
      points_in_use = (32'(grid_points) < 32'(GRID_DEPTH)) ? 32'(grid_points)
                                                           : 32'(GRID_DEPTH);
      idx_next = 32'(req_payload.position[POS_W-1:FRAC_BITS]) + 32'd1;
      item.kind          = req_payload.kind;
      item.off_grid      = (points_in_use < 32'd2) || (idx_next >= points_in_use);
      item.position      = req_payload.position;
      item.deposit_value = req_payload.deposit_value;
   end

   assign busy = back_status.clearing || (count_ff == 2'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = back_status.pop;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign queue_head.valid = (count_ff != 2'd0);
   assign queue_head.item  = queue_ff[rd_ptr_ff];

endmodule

// ----- design/lwgd_back.sv -----
// ----------------------------------------------------------------------------
// lwgd_back
// Carries out queued items against the grid, held in an even and an odd bank
// so that both neighboring points are read and written together. Clears the
// grid after reset.
// ----------------------------------------------------------------------------
module lwgd_back
   import lwgd_pkg::*;
#(
   parameter int GRID_DEPTH = GRID_DEPTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  queue_head_type  queue_head,
   output back_status_type back_status,
   output logic            rsp_strobe,
   output rsp_type         rsp_payload
);

   localparam int EVEN_DEPTH = (GRID_DEPTH + 1) / 2;
   localparam int ODD_DEPTH  = GRID_DEPTH / 2;
   localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
   localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
   localparam int IDX_W      = POS_W - FRAC_BITS;
   localparam int PROD_W     = VAL_W + FRAC_BITS + 1;
   localparam int DIFF_W     = FIELD_W + 1;
   localparam int DH_W       = DIFF_W - FRAC_BITS;
   localparam int PH_W       = DH_W + FRAC_BITS + 1;
   localparam int HI_W       = PROD_W - FRAC_BITS;
   localparam int LO_W       = VAL_W + 2;
   localparam int SUM_W      = FIELD_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIFF = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [FIELD_W-1:0] STORE_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic [FIELD_W-1:0] STORE_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   function automatic logic [FIELD_W-1:0] clamp(input logic [SUM_W-1:0] s);
      logic [FIELD_W-1:0] r;
      if (s[SUM_W-1] != s[SUM_W-2]) begin
         r = s[SUM_W-1] ? STORE_MIN : STORE_MAX;
      end else begin
         r = s[FIELD_W-1:0];
      end
      return r;
   endfunction

   logic [1:0]              state_ff, state_in;
   logic                    clearing_ff, clearing_in;
   logic [EVEN_AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    kind_ff;
   logic                    off_grid_ff;
   logic                    lsb_ff;
   logic [FRAC_BITS-1:0]    frac_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic [EVEN_AW-1:0]      addr_even_ff;
   logic [ODD_AW-1:0]       addr_odd_ff;
   logic [FIELD_W-1:0]      ga_ff, gb_ff;
   logic [DIFF_W-1:0]       diff_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [PH_W-1:0]         ph_ff;
   logic [2*FRAC_BITS-1:0]  pl_ff;
   logic [SUM_W-1:0]        sum_a_ff, sum_b_ff;

   logic [IDX_W-1:0]        idx;
   logic [31:0]             idx_ext, idx_inc;
   logic [EVEN_AW-1:0]      rd_addr_even;
   logic [ODD_AW-1:0]       rd_addr_odd;
   logic [FIELD_W-1:0]      rd_even, rd_odd;
   logic [FIELD_W-1:0]      ga, gb;
   logic [DIFF_W-1:0]       diff_in;
   logic [PROD_W-1:0]       prod_in;
   logic [PH_W-1:0]         ph_in;
   logic [2*FRAC_BITS-1:0]  pl_in;
   logic [HI_W-1:0]         hi;
   logic [LO_W-1:0]         lo;
   logic [SUM_W-1:0]        sum_a_in, sum_b_in;
   logic [FIELD_W-1:0]      new_a, new_b;
   logic                    saturated;
   logic [PH_W-1:0]         gather_sum;
   logic                    pop;
   logic                    op_write;

   logic                    we_even, we_odd;
   logic [EVEN_AW-1:0]      wa_even;
   logic [ODD_AW-1:0]       wa_odd;
   logic [FIELD_W-1:0]      wd_even, wd_odd;

   always_comb begin
      idx          = queue_head.item.position[POS_W-1:FRAC_BITS];
      idx_ext      = 32'(idx);
      idx_inc      = idx_ext + 32'd1;
      rd_addr_even = idx_inc[EVEN_AW:1];
      rd_addr_odd  = idx_ext[ODD_AW:1];
   end

   assign pop = (state_ff == S_IDLE) && !clearing_ff && queue_head.valid;

   always_comb begin
      ga       = lsb_ff ? rd_odd : rd_even;
      gb       = lsb_ff ? rd_even : rd_odd;
      diff_in  = $signed({gb[FIELD_W-1], gb}) - $signed({ga[FIELD_W-1], ga});
      prod_in  = PROD_W'($signed(value_ff) * $signed({1'b0, frac_ff}));
      ph_in    = PH_W'($signed(diff_ff[DIFF_W-1:FRAC_BITS]) * $signed({1'b0, frac_ff}));
      pl_in    = diff_ff[FRAC_BITS-1:0] * frac_ff;
      hi       = prod_ff[PROD_W-1:FRAC_BITS];
      lo       = {{2{value_ff[VAL_W-1]}}, value_ff} - {hi[HI_W-1], hi};
      sum_a_in = {ga_ff[FIELD_W-1], ga_ff} + {{(SUM_W-LO_W){lo[LO_W-1]}}, lo};
      sum_b_in = {gb_ff[FIELD_W-1], gb_ff} + {{(SUM_W-HI_W){hi[HI_W-1]}}, hi};
      new_a    = clamp(sum_a_ff);
      new_b    = clamp(sum_b_ff);
      saturated = (sum_a_ff[SUM_W-1] != sum_a_ff[SUM_W-2])
               || (sum_b_ff[SUM_W-1] != sum_b_ff[SUM_W-2]);
      gather_sum = {{2{ga_ff[FIELD_W-1]}}, ga_ff} + ph_ff
                 + {{(PH_W-FRAC_BITS){1'b0}}, pl_ff[2*FRAC_BITS-1:FRAC_BITS]};
   end

   assign op_write = (state_ff == S_DONE) && (kind_ff == KIND_DEPOSIT) && !off_grid_ff;

   always_comb begin
      if (clearing_ff) begin
         we_even = 1'b1;
         we_odd  = (32'(clr_cnt_ff) < 32'(ODD_DEPTH));
         wa_even = clr_cnt_ff;
         wa_odd  = ODD_AW'(clr_cnt_ff);
         wd_even = '0;
         wd_odd  = '0;
      end else begin
         we_even = op_write;
         we_odd  = op_write;
         wa_even = addr_even_ff;
         wa_odd  = addr_odd_ff;
         wd_even = lsb_ff ? new_b : new_a;
         wd_odd  = lsb_ff ? new_a : new_b;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clearing_in   = clearing_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + EVEN_AW'(1);
         if (clr_cnt_ff == EVEN_AW'(EVEN_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            if (off_grid_ff) begin
               rsp_in.field_value = '0;
               rsp_in.status      = STATUS_OFF_GRID;
            end else if (kind_ff == KIND_DEPOSIT) begin
               rsp_in.field_value = '0;
               rsp_in.status      = saturated ? STATUS_SATURATED : STATUS_DONE;
            end else begin
               rsp_in.field_value = gather_sum[FIELD_W-1:0];
               rsp_in.status      = STATUS_DONE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         clearing_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clearing_ff   <= clearing_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pop) begin
         kind_ff      <= queue_head.item.kind;
         off_grid_ff  <= queue_head.item.off_grid;
         lsb_ff       <= queue_head.item.position[FRAC_BITS];
         frac_ff      <= queue_head.item.position[FRAC_BITS-1:0];
         value_ff     <= queue_head.item.deposit_value;
         addr_even_ff <= rd_addr_even;
         addr_odd_ff  <= rd_addr_odd;
      end
      if (state_ff == S_DIFF) begin
         ga_ff   <= ga;
         gb_ff   <= gb;
         diff_ff <= diff_in;
         prod_ff <= prod_in;
      end
      if (state_ff == S_MUL) begin
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   lwgd_ram #(
      .WIDTH  (FIELD_W),
      .DEPTH  (EVEN_DEPTH),
      .ADDR_W (EVEN_AW)
   ) u_ram_even (
      .clock   (clock),
      .wr_en   (we_even),
      .wr_addr (wa_even),
      .wr_data (wd_even),
      .rd_addr (rd_addr_even),
      .rd_data (rd_even)
   );

   lwgd_ram #(
      .WIDTH  (FIELD_W),
      .DEPTH  ((ODD_DEPTH > 0) ? ODD_DEPTH : 1),
      .ADDR_W (ODD_AW)
   ) u_ram_odd (
      .clock   (clock),
      .wr_en   (we_odd),
      .wr_addr (wa_odd),
      .wr_data (wd_odd),
      .rd_addr (rd_addr_odd),
      .rd_data (rd_odd)
   );

   assign back_status.pop      = pop;
   assign back_status.clearing = clearing_ff;
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_payload          = rsp_ff;

endmodule

// ----- design/linear_weight_grid_deposit_gather_core.sv -----
// ----------------------------------------------------------------------------
// linear_weight_grid_deposit_gather_core
// One-dimensional grid of signed Q32.16 values with linear weight deposit
// and interpolating gather.
//
// A request beat is taken at a rising edge with start high and busy low. It
// carries a kind (deposit or gather), a Q10.16 position and a Q16.16 value.
// Each request yields one response beat: rsp_strobe is high for one cycle
// with the gathered field and a status (done, off grid, saturated).
// Each item passes through the queue and then the back end, which takes one
// item at a time through bank read, difference and multiply, second multiply
// and sums, and write back, and pops the next queued item only once it is
// idle again. A two-beat queue lets requests be taken while an earlier item
// is still in the back end; busy rises when that queue is full. After reset
// the grid is cleared by a pass over every address of the even and odd banks,
// during which busy is high. The csr port writes grid_points in any cycle.
// The receiver cannot stall: each response beat is valid for one cycle only.
// ----------------------------------------------------------------------------
module linear_weight_grid_deposit_gather_core
   import lwgd_pkg::*;
#(
   parameter int GRID_DEPTH = GRID_DEPTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_payload,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [GRID_POINTS_W-1:0] csr_wr_data
);

   logic [GRID_POINTS_W-1:0] grid_points_ff;
   queue_head_type           queue_head;
   back_status_type          back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_points_ff <= GRID_POINTS_RESET;
      end else if (csr_wr_en) begin
         grid_points_ff <= csr_wr_data;
      end
   end

   lwgd_front #(
      .GRID_DEPTH (GRID_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .grid_points (grid_points_ff),
      .back_status (back_status),
      .queue_head  (queue_head)
   );

   lwgd_back #(
      .GRID_DEPTH (GRID_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_head  (queue_head),
      .back_status (back_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- design/lwgd_checker.sv -----
// ----------------------------------------------------------------------------
// lwgd_checker
// Port-level checks on the grid deposit and gather block, bound to the top.
// ----------------------------------------------------------------------------
module lwgd_checker
   import lwgd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("Block is not busy clearing after reset.");

   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("Response beat right after reset.");

   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Response beats in consecutive cycles.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.status == STATUS_DONE
                   || rsp_payload.status == STATUS_OFF_GRID
                   || rsp_payload.status == STATUS_SATURATED))
      else $error("Unknown response status.");

   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status != STATUS_DONE) |-> rsp_payload.field_value == '0)
      else $error("Nonzero field with an off-grid or saturated status.");

endmodule

bind linear_weight_grid_deposit_gather_core lwgd_checker u_lwgd_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
